@@ rtl/bks_pkg.sv @@
// Package for the bottom-k sketch: sizes, action codes, the command struct
// broadcast along the cell row, and the limit clamp. No dependencies.
package bks_pkg;

	localparam int CAPACITY = 64;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int FP_W     = 31;
	localparam int LIMIT_W  = 7;
	localparam int SHARED_W = 7;
	localparam int OTHER_W  = 7;
	localparam int UNION_W  = 8;
	localparam logic [OTHER_W-1:0] OTHER_MAX = '1;

	typedef enum logic [1:0] {
		ACT_INSERT  = 2'd0,
		ACT_CLEAR   = 2'd1,
		ACT_COMPARE = 2'd2
	} action_t;

	typedef struct packed {
		logic             insert_en;
		logic             compare_en;
		logic             run_clear;
		logic [FP_W-1:0]  fp;
		logic [CNT_W-1:0] count;
	} cell_cmd_t;

	function automatic logic [CNT_W-1:0] eff_limit(input logic [LIMIT_W-1:0] v);
		logic [CNT_W-1:0] r;
		if (v == '0) begin
			r = CNT_W'(1);
		end else if (int'(v) > CAPACITY) begin
			r = CNT_W'(CAPACITY);
		end else begin
			r = CNT_W'(v);
		end
		return r;
	endfunction

endpackage

@@ rtl/bks_cell.sv @@
// One slot of the sorted list: holds an entry and its merge-consumed flag.
// Depends on bks_pkg.
module bks_cell (
	input  logic                    clk,
	input  logic                    arst_n,
	input  bks_pkg::cell_cmd_t      cmd,
	input  logic                    match,
	input  logic [bks_pkg::IDX_W-1:0] idx,
	input  logic [bks_pkg::FP_W-1:0]  entry_prev,
	input  logic                    lt_prev,
	input  logic                    consumed_prev,
	output logic [bks_pkg::FP_W-1:0]  entry_q,
	output logic                    lt,
	output logic                    consumed_q,
	output logic                    hit,
	output logic                    below
);
	import bks_pkg::*;

	logic first;
	logic valid;
	logic eq;
	logic is_p;

	assign first = (idx == '0);
	assign valid = CNT_W'(idx) < cmd.count;
	assign lt    = valid && (entry_q < cmd.fp);
	assign eq    = valid && (entry_q == cmd.fp);
	assign below = lt || !valid;
	assign is_p  = !consumed_q && !lt && (first || consumed_prev || lt_prev);
	assign hit   = is_p && eq;

	always_ff @(posedge clk) begin
		if (cmd.insert_en && !lt) begin
			entry_q <= (first || lt_prev) ? cmd.fp : entry_prev;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			consumed_q <= 1'b0;
		end else if (cmd.run_clear) begin
			consumed_q <= 1'b0;
		end else if (cmd.compare_en) begin
			consumed_q <= consumed_q || lt || (is_p && match);
		end
	end

endmodule

@@ rtl/bks_cell_row.sv @@
// Chain of sketch cells with the reductions that the control needs.
// Depends on bks_pkg and bks_cell.
module bks_cell_row (
	input  logic               clk,
	input  logic               arst_n,
	input  bks_pkg::cell_cmd_t cmd,
	output logic               match,
	output logic               all_below
);
	import bks_pkg::*;

	logic [FP_W-1:0]     ent  [CAPACITY];
	logic [CAPACITY-1:0] lt_v;
	logic [CAPACITY-1:0] cons_v;
	logic [CAPACITY-1:0] hit_v;
	logic [CAPACITY-1:0] below_v;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [FP_W-1:0] e_prev;
		logic            l_prev;
		logic            c_prev;
		if (i == 0) begin : g_head
			assign e_prev = '0;
			assign l_prev = 1'b0;
			assign c_prev = 1'b0;
		end else begin : g_link
			assign e_prev = ent[i-1];
			assign l_prev = lt_v[i-1];
			assign c_prev = cons_v[i-1];
		end
		bks_cell u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.cmd           (cmd),
			.match         (match),
			.idx           (IDX_W'(i)),
			.entry_prev    (e_prev),
			.lt_prev       (l_prev),
			.consumed_prev (c_prev),
			.entry_q       (ent[i]),
			.lt            (lt_v[i]),
			.consumed_q    (cons_v[i]),
			.hit           (hit_v[i]),
			.below         (below_v[i])
		);
	end

	assign match     = |hit_v;
	assign all_below = &below_v;

endmodule

@@ rtl/bottom_k_sketch_with_overlap.sv @@
// Bottom-k fingerprint sketch with merge-based overlap counting.
// The result of an item is registered and shown in the cycle after acceptance.
// One item per cycle while in_ready is high (no cfg_valid, output taken); every cell compares and shifts in parallel.
// Reset clears the count, the run state and the output valid; limit resets to 64.
// Depends on bks_pkg and bks_cell_row.
module bottom_k_sketch_with_overlap (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [bks_pkg::LIMIT_W-1:0] cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  action,
	input  logic [bks_pkg::FP_W-1:0]    fingerprint,
	input  logic                        last,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [6:0]                  kept_count,
	output logic [6:0]                  shared_count,
	output logic [7:0]                  union_count,
	output logic                        compare_done
);
	import bks_pkg::*;

	logic [LIMIT_W-1:0]  limit_q;
	logic [CNT_W-1:0]    count_q;
	logic [SHARED_W-1:0] match_q;
	logic [OTHER_W-1:0]  other_q;
	logic                out_valid_q;

	logic                accept;
	logic [CNT_W-1:0]    lim;
	logic                match;
	logic                all_below;
	logic                ignore;
	cell_cmd_t           cmd;
	action_t             act;

	logic [CNT_W-1:0]    count_d;
	logic [SHARED_W-1:0] match_d;
	logic [OTHER_W-1:0]  other_d;
	logic [SHARED_W-1:0] shared_d;
	logic [UNION_W-1:0]  union_d;
	logic                done_d;

	assign cfg_ready = 1'b1;
	assign in_ready  = (!out_valid_q || out_ready) && !cfg_valid;
	assign accept    = in_valid && in_ready;
	assign lim       = eff_limit(limit_q);
	assign act       = action_t'(action);
	assign ignore    = (count_q == lim) && all_below;

	always_comb begin
		cmd            = '0;
		cmd.fp         = fingerprint;
		cmd.count      = count_q;
		count_d        = count_q;
		match_d        = match_q;
		other_d        = other_q;
		shared_d       = match_q;
		union_d        = '0;
		done_d         = 1'b0;
		case (act)
			ACT_INSERT: begin
				cmd.insert_en = accept && !ignore;
				cmd.run_clear = accept;
				if (!ignore && count_q < lim) begin
					count_d = count_q + CNT_W'(1);
				end
				match_d  = '0;
				other_d  = '0;
				shared_d = '0;
			end
			ACT_CLEAR: begin
				cmd.run_clear = accept;
				count_d  = '0;
				match_d  = '0;
				other_d  = '0;
				shared_d = '0;
			end
			ACT_COMPARE: begin
				cmd.compare_en = accept;
				match_d  = match_q + SHARED_W'(match);
				other_d  = (other_q == OTHER_MAX) ? other_q : other_q + OTHER_W'(1);
				shared_d = match_d;
				if (last) begin
					cmd.run_clear = accept;
					done_d  = 1'b1;
					union_d = UNION_W'(count_q) + UNION_W'(other_d) - UNION_W'(match_d);
					match_d = '0;
					other_d = '0;
				end
			end
			default: begin
			end
		endcase
	end

	bks_cell_row u_row (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.match     (match),
		.all_below (all_below)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q     <= LIMIT_W'(64);
			count_q     <= '0;
			match_q     <= '0;
			other_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				limit_q <= cfg_data;
				if (count_q > eff_limit(cfg_data)) begin
					count_q <= eff_limit(cfg_data);
				end
			end else if (accept) begin
				count_q <= count_d;
				match_q <= match_d;
				other_q <= other_d;
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kept_count   <= 7'(count_d);
			shared_count <= 7'(shared_d);
			union_count  <= 8'(union_d);
			compare_done <= done_d;
		end
	end

	assign out_valid = out_valid_q;

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= lim)
		else $error("Kept count exceeds the effective limit.");

	assert property (@(posedge clk) disable iff (!arst_n) match_q <= other_q)
		else $error("Shared count exceeds the number of compared elements.");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && compare_done |-> union_count >= 8'(kept_count))
		else $error("Union count below kept count at the end of a compare run.");

	assert property (@(posedge clk) disable iff (!arst_n)
		accept && act == ACT_CLEAR |=> count_q == '0 && match_q == '0)
		else $error("Clear did not empty the list and the run state.");

endmodule

@@ sim/tb_bottom_k_sketch_with_overlap.sv @@
// Testbench for bottom_k_sketch_with_overlap: directed and random inserts, clears and
// compare runs, checked item by item against a scoreboard that tracks the sorted list.
// Depends on bks_pkg and the block under test; needs nothing else.
module tb_bottom_k_sketch_with_overlap;
	import bks_pkg::*;

	localparam logic [1:0] ACT_SPARE = 2'd3;
	localparam logic [FP_W-1:0] FP_MAX = '1;

	typedef struct packed {
		logic [6:0] kept_n;
		logic [6:0] shared_n;
		logic [7:0] union_n;
		logic       done;
	} counts_t;

	class sketch_scoreboard;
		bit [FP_W-1:0] entries [CAPACITY];
		bit [6:0] count;
		bit [6:0] ptr;
		bit [6:0] match_n;
		bit [6:0] others;
		bit [LIMIT_W-1:0] limit;
		counts_t awaited [$];
		int errors;

		function new();
			count = 0;
			limit = 7'd64;
			errors = 0;
			drop_run();
		endfunction

		function void drop_run();
			ptr = 0;
			match_n = 0;
			others = 0;
		endfunction

		function int clamp_limit();
			if (limit == 0) begin
				return 1;
			end
			if (int'(limit) > CAPACITY) begin
				return CAPACITY;
			end
			return int'(limit);
		endfunction

		function void note_config(bit [LIMIT_W-1:0] v);
			limit = v;
			if (int'(count) > clamp_limit()) begin
				count = 7'(clamp_limit());
			end
		endfunction

		function void insert_fp(bit [FP_W-1:0] fp);
			int lim;
			int rank;
			int i;
			lim = clamp_limit();
			if (int'(count) > lim) begin
				count = 7'(lim);
			end
			if (int'(count) == lim && fp > entries[count - 1]) begin
				return;
			end
			rank = 0;
			while (rank < int'(count) && entries[rank] < fp) begin
				rank++;
			end
			if (int'(count) < lim) begin
				count++;
			end
			for (i = int'(count) - 1; i > rank; i--) begin
				entries[i] = entries[i - 1];
			end
			entries[rank] = fp;
		endfunction

		function void note_item(logic [1:0] act, logic [FP_W-1:0] fp, logic lst);
			counts_t c;
			c = '0;
			case (act)
				ACT_INSERT: begin
					drop_run();
					insert_fp(fp);
				end
				ACT_CLEAR: begin
					count = 0;
					drop_run();
				end
				ACT_COMPARE: begin
					while (ptr < count && entries[ptr] < fp) begin
						ptr++;
					end
					if (ptr < count && entries[ptr] == fp) begin
						match_n++;
						ptr++;
					end
					if (others < 7'd127) begin
						others++;
					end
				end
				default: ;
			endcase
			c.shared_n = match_n;
			if (act == ACT_COMPARE && lst) begin
				c.done = 1'b1;
				c.union_n = UNION_W'(int'(count) + int'(others) - int'(match_n));
				drop_run();
			end
			c.kept_n = count;
			awaited = {awaited, c};
		endfunction

		function void check_result(logic [6:0] k, logic [6:0] s, logic [7:0] u, logic d);
			counts_t got;
			counts_t want;
			got = {k, s, u, d};
			if (awaited.size() == 0) begin
				$display("%0t: unexpected result: kept %0d shared %0d union %0d done %0d",
					$time, k, s, u, d);
				errors++;
				return;
			end
			want = awaited.pop_front();
			if (got !== want) begin
				$display("%0t: mismatch: expected kept %0d shared %0d union %0d done %0d, %s",
					$time, want.kept_n, want.shared_n, want.union_n, want.done,
					$sformatf("got kept %0d shared %0d union %0d done %0d", k, s, u, d));
				errors++;
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [LIMIT_W-1:0]   cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic [1:0]           action;
	logic [FP_W-1:0]      fingerprint;
	logic                 last;
	logic                 out_valid;
	logic                 out_ready;
	logic [6:0]           kept_count;
	logic [6:0]           shared_count;
	logic [7:0]           union_count;
	logic                 compare_done;

	sketch_scoreboard sb = new();
	bit calm = 1'b0;
	bit hold_request = 1'b0;
	int items_sent = 0;

	bottom_k_sketch_with_overlap dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.fingerprint  (fingerprint),
		.last         (last),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.kept_count   (kept_count),
		.shared_count (shared_count),
		.union_count  (union_count),
		.compare_done (compare_done)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 50) begin
			return 0;
		end else if (r < 85) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [FP_W-1:0] rand_fp();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4) begin
			return FP_W'($urandom);
		end else if (r < 8) begin
			return FP_W'($urandom_range(0, 63));
		end
		return FP_MAX - FP_W'($urandom_range(0, 63));
	endfunction

	task automatic send_item(input logic [1:0] act, input logic [FP_W-1:0] fp, input logic lst);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		fingerprint <= fp;
		last <= lst;
		do @(posedge clk); while (!in_ready);
		sb.note_item(act, fp, lst);
		if (act != ACT_SPARE) begin
			items_sent++;
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.awaited.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic set_limit(input logic [LIMIT_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		sb.note_config(v);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_compare(input bit mess);
		logic [FP_W-1:0] other_list [$];
		logic [FP_W-1:0] prev;
		int i;
		int n;
		int step;
		prev = '0;
		for (i = 0; i < int'(sb.count); i++) begin
			if ($urandom_range(0, 3) == 0 && sb.entries[i] > prev) begin
				other_list = {other_list, prev + FP_W'($urandom % (sb.entries[i] - prev))};
			end
			if ($urandom_range(0, 3) != 0) begin
				other_list = {other_list, sb.entries[i]};
			end
			if ($urandom_range(0, 7) == 0) begin
				other_list = {other_list, sb.entries[i]};
			end
			prev = sb.entries[i];
		end
		n = $urandom_range(0, 3);
		for (i = 0; i < n; i++) begin
			step = $urandom_range(0, 1000);
			if (int'(FP_MAX - prev) < step) begin
				prev = FP_MAX;
			end else begin
				prev = prev + FP_W'(step);
			end
			other_list = {other_list, prev};
		end
		if (other_list.size() == 0) begin
			other_list = {other_list, rand_fp()};
		end
		if (mess) begin
			other_list[$urandom_range(0, other_list.size() - 1)] = rand_fp();
		end
		for (i = 0; i < other_list.size(); i++) begin
			if (mess && $urandom_range(0, 9) == 0) begin
				send_item(ACT_SPARE, rand_fp(), 1'($urandom_range(0, 1)));
			end
			if (mess && $urandom_range(0, 15) == 0) begin
				if ($urandom_range(0, 1) == 0) begin
					send_item(ACT_INSERT, rand_fp(), 1'($urandom_range(0, 1)));
				end else begin
					send_item(ACT_CLEAR, rand_fp(), 1'($urandom_range(0, 1)));
				end
			end
			send_item(ACT_COMPARE, other_list[i], i == other_list.size() - 1);
		end
	endtask

	task automatic long_run();
		logic [FP_W-1:0] v;
		int n;
		int i;
		n = $urandom_range(130, 150);
		v = FP_W'($urandom_range(0, 20));
		for (i = 0; i < n; i++) begin
			send_item(ACT_COMPARE, v, i == n - 1);
			v = v + FP_W'($urandom_range(0, 3));
		end
	endtask

	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			sb.check_result(kept_count, shared_count, union_count, compare_done);
		end
	end

	initial begin
		int n;
		out_ready = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				out_ready <= 1'b0;
				repeat (300) @(posedge clk);
			end else if (calm) begin
				out_ready <= 1'b1;
				@(posedge clk);
			end else begin
				n = pick_gap();
				if (n > 0) begin
					out_ready <= 1'b0;
					repeat (n) @(posedge clk);
				end
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	end

	initial begin
		#20000000;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		int phase;
		int r;
		int n;
		int i;
		int runs;
		logic [LIMIT_W-1:0] lim;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		action = '0;
		fingerprint = '0;
		last = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(ACT_COMPARE, 31'd77, 1'b1);
		send_item(ACT_INSERT, FP_MAX, 1'b0);
		send_item(ACT_INSERT, 31'd0, 1'b1);
		send_item(ACT_INSERT, 31'd5, 1'b0);
		send_item(ACT_INSERT, 31'd5, 1'b0);
		send_item(ACT_INSERT, 31'd3, 1'b0);
		send_item(ACT_COMPARE, 31'd0, 1'b0);
		send_item(ACT_COMPARE, 31'd5, 1'b0);
		send_item(ACT_SPARE, FP_MAX, 1'b1);
		send_item(ACT_COMPARE, 31'd5, 1'b0);
		send_item(ACT_COMPARE, FP_MAX, 1'b1);
		send_item(ACT_COMPARE, 31'd9, 1'b0);
		send_item(ACT_COMPARE, 31'd2, 1'b0);
		send_item(ACT_COMPARE, 31'd5, 1'b1);
		send_item(ACT_COMPARE, 31'd3, 1'b0);
		send_item(ACT_INSERT, 31'd7, 1'b0);
		send_item(ACT_COMPARE, 31'd3, 1'b1);
		send_item(ACT_COMPARE, 31'd0, 1'b0);
		send_item(ACT_CLEAR, 31'd0, 1'b1);
		send_item(ACT_COMPARE, 31'd0, 1'b1);
		send_item(ACT_INSERT, 31'd10, 1'b0);
		send_item(ACT_INSERT, 31'd20, 1'b0);
		send_item(ACT_INSERT, 31'd30, 1'b0);
		drain();
		set_limit(7'd2);
		send_item(ACT_INSERT, 31'd25, 1'b0);
		send_item(ACT_INSERT, 31'd15, 1'b0);
		send_item(ACT_INSERT, 31'd10, 1'b0);
		drain();
		set_limit(7'd0);
		send_item(ACT_INSERT, FP_MAX, 1'b0);
		send_item(ACT_INSERT, 31'd4, 1'b0);
		drain();
		set_limit(7'd127);
		send_item(ACT_INSERT, 31'd1, 1'b0);

		phase = 0;
		while (items_sent < 1200) begin
			drain();
			r = $urandom_range(0, 9);
			case (r)
				0: lim = 7'd0;
				1: lim = 7'd1;
				2: lim = 7'd64;
				3: lim = 7'd127;
				4: lim = 7'($urandom_range(65, 127));
				5, 6: lim = 7'($urandom_range(1, 8));
				default: lim = 7'($urandom_range(1, 64));
			endcase
			set_limit(lim);
			calm = (phase % 7 == 2);
			if (phase == 3 || phase == 17) begin
				hold_request = 1'b1;
			end
			if ($urandom_range(0, 4) == 0) begin
				send_item(ACT_CLEAR, rand_fp(), 1'($urandom_range(0, 1)));
			end
			n = $urandom_range(0, sb.clamp_limit() + 8);
			for (i = 0; i < n; i++) begin
				send_item(ACT_INSERT, rand_fp(), 1'($urandom_range(0, 1)));
			end
			if (phase == 5) begin
				long_run();
			end
			runs = $urandom_range(1, 3);
			for (i = 0; i < runs; i++) begin
				run_compare($urandom_range(0, 5) == 0);
			end
			phase++;
		end
		drain();
		repeat (4) @(posedge clk);

		if (sb.errors == 0 && sb.awaited.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
